@@ rtl/cps_pkg.sv @@
`default_nettype none

package cps_pkg;

    localparam int NUM_WIDTHS  = 3;
    localparam int HOLD_TICKS  = 50;
    localparam int CNT_W       = 6;
    localparam int TALLY_W     = 8;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [15:0] INVALID_VOLTS = 16'hFFFF;

    // pulse width codes, also the slot contents (zero = empty slot)
    typedef logic [1:0] t_code;
    localparam t_code CODE_NONE  = 2'd0;
    localparam t_code CODE_SHORT = 2'd1;
    localparam t_code CODE_MID   = 2'd2;
    localparam t_code CODE_LONG  = 2'd3;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_CALLBACK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUST_SHORT = 3'd0,
        CFG_CUST_MID   = 3'd1,
        CFG_CUST_LONG  = 3'd2,
        CFG_DIAG_SHORT = 3'd3,
        CFG_DIAG_MID   = 3'd4,
        CFG_DIAG_LONG  = 3'd5,
        CFG_MAX_PULSES = 3'd6,
        CFG_OV_LIMIT   = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

@@ rtl/crash_pulse_sequencer.sv @@
`default_nettype none

// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+---------------------------------
// s_axis    | in  | s_axis_tvalid/tready       | tick or callback item
// m_axis    | out | m_axis_tvalid/tready       | one result per item
// cfg       | in  | i_cfg_valid/o_cfg_ready    | register index + write data
//
// The state update is done combinationally between the accepted transfer and the
// result register, so one item per clock is taken while m_axis is not stalled.
// The result shows on m_axis the cycle after acceptance; the single output
// register takes a new item in the same cycle its result is drained.
// A stalled m_axis holds s_axis_tready low until the result is taken.
// Synchronous active-low reset clears all state but r_out_data and loads register defaults.

module crash_pulse_sequencer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // [31:0] cust_triggers, [63:32] diag_set, [64] diag_request,
    // [80:65] battery_volts, [96:81] ignition_volts, [97] output_configured,
    // [98] selftest_passed, [103:99] zero
    input  wire logic [cps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] op
    input  wire logic [cps_pkg::IN_TUSER_W-1:0]     s_axis_tuser,

    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] pulse_start, [2] idle_ack, [3] output_active,
    // [4] activation_allowed, [5] steady, [7:6] zero
    output      logic [cps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [cps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [cps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import cps_pkg::*;

    // configuration
    logic [31:0]          r_cust_mask [NUM_WIDTHS];
    logic [31:0]          r_diag_mask [NUM_WIDTHS];
    logic [TALLY_W-1:0]   r_max_pulses;
    logic [15:0]          r_ov_limit;

    // sequencer state
    logic                 r_steady,     n_steady;
    logic                 r_allowed,    n_allowed;
    logic [CNT_W-1:0]     r_ov_cnt,     n_ov_cnt;
    logic                 r_active   [NUM_WIDTHS];
    logic                 n_active   [NUM_WIDTHS];
    t_code                r_slot     [NUM_WIDTHS];
    t_code                n_slot     [NUM_WIDTHS];
    logic [1:0]           r_ptr,        n_ptr;
    logic [TALLY_W-1:0]   r_tally    [NUM_WIDTHS];
    logic [TALLY_W-1:0]   n_tally    [NUM_WIDTHS];
    logic                 r_running,    n_running;
    logic                 r_diag_flag,  n_diag_flag;
    logic [31:0]          r_diag_latched, n_diag_latched;

    // output register
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // input fields
    logic                 in_op;
    logic [31:0]          in_cust;
    logic [31:0]          in_diag_set;
    logic                 in_diag_req;
    logic [15:0]          in_bat;
    logic [15:0]          in_ign;
    logic                 in_out_cfg;
    logic                 in_selftest;

    logic                 s_fire;
    logic                 ov_now;
    t_code                started;
    t_code                code;
    logic                 idle;

    assign in_op       = s_axis_tuser[0];
    assign in_cust     = s_axis_tdata[31:0];
    assign in_diag_set = s_axis_tdata[63:32];
    assign in_diag_req = s_axis_tdata[64];
    assign in_bat      = s_axis_tdata[80:65];
    assign in_ign      = s_axis_tdata[96:81];
    assign in_out_cfg  = s_axis_tdata[97];
    assign in_selftest = s_axis_tdata[98];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // 0xFFFF is an invalid reading and never counts
    assign ov_now = (in_bat >= r_ov_limit && in_bat != INVALID_VOLTS) ||
                    (in_ign >= r_ov_limit && in_ign != INVALID_VOLTS);

    always_comb begin
        n_steady       = r_steady;
        n_allowed      = r_allowed;
        n_ov_cnt       = r_ov_cnt;
        n_ptr          = r_ptr;
        n_running      = r_running;
        n_diag_flag    = r_diag_flag;
        n_diag_latched = r_diag_latched;
        n_active       = r_active;
        n_slot         = r_slot;
        n_tally        = r_tally;
        started        = CODE_NONE;
        idle           = 1'b0;
        code           = CODE_NONE;

        if (in_op == OP_TICK) begin
            n_diag_latched = r_diag_latched | in_diag_set;
            if (in_diag_req) begin
                n_diag_flag = 1'b1;
            end

            if (!r_steady) begin
                if (in_out_cfg && in_selftest) begin
                    n_steady = 1'b1;
                end
            end else begin
                // overvoltage debounce
                if (ov_now) begin
                    if (r_ov_cnt < CNT_W'(HOLD_TICKS)) begin
                        n_ov_cnt = r_ov_cnt + 1'b1;
                    end else begin
                        n_allowed = 1'b0;
                        for (int k = 0; k < NUM_WIDTHS; k++) begin
                            n_active[k] = 1'b0;
                            n_slot[k]   = CODE_NONE;
                            n_tally[k]  = '0;
                        end
                    end
                end else begin
                    n_ov_cnt  = '0;
                    n_allowed = 1'b1;
                end

                // trigger collection, widths taken in order short..long
                if (n_allowed && (in_cust != '0 || n_diag_latched != '0)) begin
                    for (int w = 0; w < NUM_WIDTHS; w++) begin
                        if ((in_cust & r_cust_mask[w]) != '0 ||
                            ((n_diag_latched & r_diag_mask[w]) != '0 && n_diag_flag)) begin
                            code       = t_code'(w + 1);
                            n_tally[w] = '0;
                            n_active[w] = 1'b1;
                            if (n_slot[0] != code && n_slot[1] != code &&
                                n_slot[2] != code) begin
                                if (n_slot[0] == CODE_NONE) begin
                                    n_slot[0] = code;
                                end else if (n_slot[1] == CODE_NONE) begin
                                    n_slot[1] = code;
                                end else begin
                                    n_slot[2] = code;
                                end
                            end
                            n_diag_latched = n_diag_latched & ~r_diag_mask[w];
                        end
                    end
                    if (!n_running) begin
                        n_running = 1'b1;
                        n_ptr     = 2'd0;
                        started   = n_slot[0];
                        if (started != CODE_NONE &&
                            n_tally[started - 1'b1] != {TALLY_W{1'b1}}) begin
                            n_tally[started - 1'b1] = n_tally[started - 1'b1] + 1'b1;
                        end
                    end
                end

                // retire finished widths and close up the sequence
                if (n_active[0] || n_active[1] || n_active[2]) begin
                    for (int w = 0; w < NUM_WIDTHS; w++) begin
                        code = t_code'(w + 1);
                        if (n_tally[w] >= r_max_pulses) begin
                            n_active[w] = 1'b0;
                            n_tally[w]  = '0;
                            if (n_slot[0] == code) begin
                                n_slot[0] = n_slot[1];
                                n_slot[1] = n_slot[2];
                                n_slot[2] = CODE_NONE;
                            end else if (n_slot[1] == code) begin
                                n_slot[1] = n_slot[2];
                                n_slot[2] = CODE_NONE;
                            end else if (n_slot[2] == code) begin
                                n_slot[2] = CODE_NONE;
                            end
                        end
                    end
                end else if (n_running) begin
                    n_running   = 1'b0;
                    n_ptr       = 2'd0;
                    n_diag_flag = 1'b0;
                end
            end
        end else if (r_running) begin
            // callback: step round-robin, wrap to slot 0 on an empty slot
            n_ptr = (r_ptr == 2'd2) ? 2'd0 : r_ptr + 2'd1;
            if (r_slot[n_ptr] == CODE_NONE) begin
                n_ptr = 2'd0;
            end
            started = r_slot[n_ptr];
            if (started != CODE_NONE &&
                r_tally[started - 1'b1] != {TALLY_W{1'b1}}) begin
                n_tally[started - 1'b1] = r_tally[started - 1'b1] + 1'b1;
            end
        end else begin
            idle = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WIDTHS; k++) begin
                r_cust_mask[k] <= 32'(1 << k);
                r_diag_mask[k] <= 32'(1 << k);
                r_active[k]    <= 1'b0;
                r_slot[k]      <= CODE_NONE;
                r_tally[k]     <= '0;
            end
            r_max_pulses   <= TALLY_W'(5);
            r_ov_limit     <= 16'd2200;
            r_steady       <= 1'b0;
            r_allowed      <= 1'b1;
            r_ov_cnt       <= '0;
            r_ptr          <= 2'd0;
            r_running      <= 1'b0;
            r_diag_flag    <= 1'b0;
            r_diag_latched <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CUST_SHORT: r_cust_mask[0] <= i_cfg_data;
                    CFG_CUST_MID:   r_cust_mask[1] <= i_cfg_data;
                    CFG_CUST_LONG:  r_cust_mask[2] <= i_cfg_data;
                    CFG_DIAG_SHORT: r_diag_mask[0] <= i_cfg_data;
                    CFG_DIAG_MID:   r_diag_mask[1] <= i_cfg_data;
                    CFG_DIAG_LONG:  r_diag_mask[2] <= i_cfg_data;
                    CFG_MAX_PULSES: r_max_pulses   <= i_cfg_data[TALLY_W-1:0];
                    CFG_OV_LIMIT:   r_ov_limit     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (s_fire) begin
                r_steady       <= n_steady;
                r_allowed      <= n_allowed;
                r_ov_cnt       <= n_ov_cnt;
                r_active       <= n_active;
                r_slot         <= n_slot;
                r_ptr          <= n_ptr;
                r_tally        <= n_tally;
                r_running      <= n_running;
                r_diag_flag    <= n_diag_flag;
                r_diag_latched <= n_diag_latched;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= {2'b00, n_steady, n_allowed, n_running, idle, started};
        end
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import cps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // tdata layout of one input item, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic        stp;
        logic        cfgd;
        logic [15:0] ign;
        logic [15:0] bat;
        logic        dreq;
        logic [31:0] dset;
        logic [31:0] cust;
    } crash_word_t;

    typedef struct {
        logic        op;
        crash_word_t word;
    } crash_item_t;

    typedef struct packed {
        logic [1:0] pad;
        logic       steady;
        logic       allowed;
        logic       active;
        logic       idle;
        t_code      pulse;
    } pulse_report_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    s_valid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [IN_TUSER_W-1:0]   s_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    crash_pulse_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // register copies
    logic [31:0] cust_msk [NUM_WIDTHS];
    logic [31:0] diag_msk [NUM_WIDTHS];
    int          max_cnt;
    int          ov_limit;

    // sequencer state copy
    logic        in_steady;
    logic        act_allowed;
    int          ov_count;
    logic        width_on [NUM_WIDTHS];
    t_code       slot [NUM_WIDTHS];
    int          slot_ptr;
    int          tally [NUM_WIDTHS];
    logic        seq_running;
    logic        diag_on;
    logic [31:0] diag_word;

    crash_item_t   stimulus_items [$];
    pulse_report_t reports_due [$];
    crash_item_t   cur_item;

    int idle_mode = 0;
    int errors = 0;
    int reports_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    function automatic logic volts_over(logic [15:0] v);
        return int'(v) >= ov_limit && v != INVALID_VOLTS;
    endfunction

    function automatic t_code begin_pulse();
        t_code code;
        code = slot[slot_ptr];
        if (code != CODE_NONE && tally[code - 1] < 255)
            tally[code - 1]++;
        return code;
    endfunction

    function automatic pulse_report_t predict_pulse_step(crash_item_t it);
        pulse_report_t r;
        t_code code;
        r = '0;
        if (it.op == OP_TICK) begin
            diag_word |= it.word.dset;
            if (it.word.dreq)
                diag_on = 1'b1;
            if (!in_steady) begin
                if (it.word.cfgd && it.word.stp)
                    in_steady = 1'b1;
            end else begin
                if (volts_over(it.word.bat) || volts_over(it.word.ign)) begin
                    if (ov_count < HOLD_TICKS) begin
                        ov_count++;
                    end else begin
                        act_allowed = 1'b0;
                        for (int k = 0; k < NUM_WIDTHS; k++) begin
                            width_on[k] = 1'b0;
                            slot[k] = CODE_NONE;
                            tally[k] = 0;
                        end
                    end
                end else begin
                    ov_count = 0;
                    act_allowed = 1'b1;
                end
                if (act_allowed && (it.word.cust != 0 || diag_word != 0)) begin
                    for (int w = 0; w < NUM_WIDTHS; w++) begin
                        if ((it.word.cust & cust_msk[w]) != 0 ||
                            ((diag_word & diag_msk[w]) != 0 && diag_on)) begin
                            code = t_code'(w + 1);
                            tally[w] = 0;
                            width_on[w] = 1'b1;
                            if (slot[0] != code && slot[1] != code && slot[2] != code) begin
                                if (slot[0] == CODE_NONE)
                                    slot[0] = code;
                                else if (slot[1] == CODE_NONE)
                                    slot[1] = code;
                                else
                                    slot[2] = code;
                            end
                            diag_word &= ~diag_msk[w];
                        end
                    end
                    if (!seq_running) begin
                        seq_running = 1'b1;
                        slot_ptr = 0;
                        r.pulse = begin_pulse();
                    end
                end
                // retire widths that reached their pulse count, close up the slots
                if (width_on[0] || width_on[1] || width_on[2]) begin
                    for (int w = 0; w < NUM_WIDTHS; w++) begin
                        code = t_code'(w + 1);
                        if (tally[w] >= max_cnt) begin
                            width_on[w] = 1'b0;
                            tally[w] = 0;
                            if (slot[0] == code) begin
                                slot[0] = slot[1];
                                slot[1] = slot[2];
                                slot[2] = CODE_NONE;
                            end else if (slot[1] == code) begin
                                slot[1] = slot[2];
                                slot[2] = CODE_NONE;
                            end else if (slot[2] == code) begin
                                slot[2] = CODE_NONE;
                            end
                        end
                    end
                end else if (seq_running) begin
                    seq_running = 1'b0;
                    slot_ptr = 0;
                    diag_on = 1'b0;
                end
            end
        end else if (seq_running) begin
            slot_ptr = (slot_ptr + 1) % NUM_WIDTHS;
            if (slot[slot_ptr] == CODE_NONE)
                slot_ptr = 0;
            r.pulse = begin_pulse();
        end else begin
            r.idle = 1'b1;
        end
        r.active = seq_running;
        r.allowed = act_allowed;
        r.steady = in_steady;
        return r;
    endfunction

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_axis_tready)
                reports_due.push_back(predict_pulse_step(cur_item));
            if (!s_valid || s_axis_tready) begin
                if (stimulus_items.size() != 0 &&
                    $urandom_range(0, 99) >= (idle_mode == 0 ? 34 : idle_mode == 1 ? 49 : 0)) begin
                    cur_item = stimulus_items.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= cur_item.word;
                    s_tuser <= cur_item.op;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        pulse_report_t got;
        pulse_report_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_ready) begin
                got = m_axis_tdata;
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h", $time, got);
                    errors++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("pulse_start", got.pulse, want.pulse);
                    check_field("idle_ack", got.idle, want.idle);
                    check_field("output_active", got.active, want.active);
                    check_field("activation_allowed", got.allowed, want.allowed);
                    check_field("steady", got.steady, want.steady);
                    check_field("pad bits", got.pad, want.pad);
                end
                reports_seen++;
                // one long back-pressure stretch fills the block up
                if (reports_seen == 150)
                    hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= (idle_mode == 0 ? 49 :
                                                     idle_mode == 1 ? 34 : 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [31:0] cust, logic [31:0] dset, logic dreq,
                             logic [15:0] bat, logic [15:0] ign, logic cfgd, logic stp);
        crash_item_t it;
        it.op = op;
        it.word = '{pad: '0, stp: stp, cfgd: cfgd, ign: ign, bat: bat, dreq: dreq,
                    dset: dset, cust: cust};
        stimulus_items.push_back(it);
    endtask

    task automatic push_tick(logic [31:0] cust, logic [31:0] dset, logic dreq,
                             logic [15:0] bat, logic [15:0] ign);
        push_item(OP_TICK, cust, dset, dreq, bat, ign,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // callbacks carry random junk in the ignored fields
    task automatic push_callback();
        push_item(OP_CALLBACK, $urandom, $urandom, 1'($urandom_range(0, 1)),
                  16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [15:0] calm_volts();
        return (ov_limit == 0) ? INVALID_VOLTS : 16'($urandom_range(0, ov_limit - 1));
    endfunction

    function automatic logic [15:0] hot_volts();
        return (ov_limit >= 16'hFFFF) ? 16'($urandom) : 16'($urandom_range(ov_limit, 16'hFFFE));
    endfunction

    function automatic logic [31:0] pick_trigger();
        case ($urandom_range(0, 3))
            0: return cust_msk[$urandom_range(0, 2)];
            1: return $urandom;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return cust_msk[$urandom_range(0, 2)] | diag_msk[$urandom_range(0, 2)];
        endcase
    endfunction

    task automatic fill_random(int count);
        int target;
        int sel;
        int len;
        target = stimulus_items.size() + count;
        while (stimulus_items.size() < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                // trigger followed by pulse-cycle callbacks and ticks, some of which carry triggers
                push_tick(pick_trigger(), 0, 1'b0, calm_volts(), calm_volts());
                len = $urandom_range(1, 14);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 25)
                        push_tick($urandom_range(0, 3) == 0 ? pick_trigger() : 32'h0, 0, 1'b0,
                                  calm_volts(), calm_volts());
                    else
                        push_callback();
                end
            end else if (sel < 67) begin
                // overvoltage run of a length on either side of the debounce limit
                len = $urandom_range(HOLD_TICKS - 5, HOLD_TICKS + 8);
                repeat (len) begin
                    case ($urandom_range(0, 2))
                        0: push_tick(0, 0, 1'b0, hot_volts(), calm_volts());
                        1: push_tick(pick_trigger(), 0, 1'b0, INVALID_VOLTS, hot_volts());
                        default: push_tick(0, 0, 1'b0, hot_volts(), hot_volts());
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        push_callback();
                end
                push_tick(pick_trigger(), 0, 1'b0, calm_volts(), calm_volts());
                push_callback();
            end else if (sel < 80) begin
                push_tick(0, $urandom_range(0, 1) ? $urandom : diag_msk[$urandom_range(0, 2)],
                          1'($urandom_range(0, 1)), calm_volts(), calm_volts());
                push_callback();
                push_tick(0, 0, 1'b1, calm_volts(), calm_volts());
                repeat ($urandom_range(1, 6))
                    push_callback();
            end else begin
                repeat ($urandom_range(1, 4))
                    push_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                              1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CUST_SHORT: cust_msk[0] = val;
            CFG_CUST_MID:   cust_msk[1] = val;
            CFG_CUST_LONG:  cust_msk[2] = val;
            CFG_DIAG_SHORT: diag_msk[0] = val;
            CFG_DIAG_MID:   diag_msk[1] = val;
            CFG_DIAG_LONG:  diag_msk[2] = val;
            CFG_MAX_PULSES: max_cnt = int'(val[7:0]);
            default:        ov_limit = int'(val[15:0]);
        endcase
    endtask

    task automatic setup_phase(int mode, logic [31:0] cs, logic [31:0] cm, logic [31:0] cl,
                               logic [31:0] ds, logic [31:0] dm, logic [31:0] dl,
                               logic [7:0] mp, logic [15:0] lim);
        write_reg(CFG_CUST_SHORT, cs);
        write_reg(CFG_CUST_MID, cm);
        write_reg(CFG_CUST_LONG, cl);
        write_reg(CFG_DIAG_SHORT, ds);
        write_reg(CFG_DIAG_MID, dm);
        write_reg(CFG_DIAG_LONG, dl);
        write_reg(CFG_MAX_PULSES, {24'h0, mp});
        write_reg(CFG_OV_LIMIT, {16'h0, lim});
        idle_mode <= mode;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (stimulus_items.size() != 0 || s_valid || reports_due.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < NUM_WIDTHS; k++) begin
            cust_msk[k] = 32'h1 << k;
            diag_msk[k] = 32'h1 << k;
            width_on[k] = 1'b0;
            slot[k] = CODE_NONE;
            tally[k] = 0;
        end
        max_cnt = 5;
        ov_limit = 2200;
        in_steady = 1'b0;
        act_allowed = 1'b1;
        ov_count = 0;
        slot_ptr = 0;
        seq_running = 1'b0;
        diag_on = 1'b0;
        diag_word = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part on reset register values
        push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 32'hFFFF_FFFF, 32'h2, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        push_item(OP_TICK, 0, 0, 1'b1, 16'd1000, 16'd1000, 1'b0, 1'b1);
        push_item(OP_CALLBACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF,
                  1'b1, 1'b1);
        // leaving init: nothing else happens on this tick
        push_item(OP_TICK, 32'h7, 0, 1'b0, 16'd1000, 16'd1000, 1'b1, 1'b1);
        push_item(OP_TICK, 0, 0, 1'b0, 16'd1000, 16'd1000, 1'b1, 1'b1);
        push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 32'h1, 0, 1'b0, 16'd1000, 16'd1000, 1'b1, 1'b1);
        repeat (5)
            push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b1, 1'b1);
        // trigger bit outside every mask
        push_item(OP_TICK, 32'h8000_0000, 0, 1'b0, 16'd1000, 16'd1000, 1'b1, 1'b1);
        push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 32'hFFFF_FFFF, 0, 1'b0, 16'd2200, 16'd0, 1'b1, 1'b1);
        push_item(OP_TICK, 0, 0, 1'b0, 16'd2199, 16'hFFFF, 1'b1, 1'b1);
        push_item(OP_TICK, 32'h4, 32'h1, 1'b1, 16'd0, 16'hFFFE, 1'b1, 1'b1);
        push_item(OP_CALLBACK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 0, 1'b0, 16'd0, 16'd0, 1'b1, 1'b1);
        wait_drained();

        // max pulse count, ov limit 3000 then 0xFFFF; one width runs till its tally saturates
        setup_phase(0, 32'h0000_000F, 32'h0000_0F00, 32'h000F_0000, 0, 0, 0, 8'd255, 16'hFFFF);
        write_reg(CFG_OV_LIMIT, 32'd3000);
        @(negedge i_clk);
        repeat (HOLD_TICKS + 2)
            push_tick(0, 0, 1'b0, hot_volts(), calm_volts());
        push_tick(0, 0, 1'b0, calm_volts(), calm_volts());
        push_tick(32'h1, 0, 1'b0, calm_volts(), calm_volts());
        repeat (270)
            push_callback();
        wait_drained();
        write_reg(CFG_OV_LIMIT, 32'h0000_FFFF);
        @(negedge i_clk);
        fill_random(30);
        wait_drained();

        // zero pulse count, every reading but the invalid one is overvoltage
        setup_phase(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 16'd0);
        fill_random(30);
        wait_drained();

        setup_phase(1, 0, 0, 0, $urandom, $urandom, $urandom, 8'd1, 16'd1000);
        fill_random(30);
        wait_drained();

        setup_phase(2, $urandom, $urandom, $urandom,
                    32'h1 << $urandom_range(0, 31), 32'h1 << $urandom_range(0, 31),
                    32'h1 << $urandom_range(0, 31),
                    8'($urandom_range(1, 8)), 16'($urandom_range(1, 65534)));
        fill_random(30);
        wait_drained();

        setup_phase(2, 32'h1, 32'h2, 32'h4, 32'h1, 32'h2, 32'h4, 8'd5, 16'd2200);
        fill_random(30);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cps_pkg.sv
rtl/crash_pulse_sequencer.sv
test/tb_top.sv
